// ===== hdl/oan_pkg.sv =====
// ----------------------------------------------------------------------------
// oan_pkg
// Shared types and constants of the oversampled angle normalizer: field
// widths, burst limit, divider sizing, sequencer states and divider bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package oan_pkg;

  // field widths
  localparam int RAW_W  = 12;
  localparam int OFFS_W = 13;
  localparam int ANG_W  = 16;

  // burst limit and accumulator widths
  localparam int MAX_BURST = 1024;
  localparam int CNT_W     = $clog2(MAX_BURST + 1);
  localparam int SUM_W     = RAW_W + CNT_W;

  // raw wrap and full scale in 1/128 degree units
  localparam logic [OFFS_W-1:0] RAW_WRAP = OFFS_W'(4096);
  localparam logic [ANG_W-1:0]  FULL_Q7  = ANG_W'(46080);

  // divider sizing: dividend covers the sum and the scaled offset
  localparam int PROD_W    = OFFS_W + ANG_W;
  localparam int DIV_N     = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DIV_D     = (CNT_W > OFFS_W) ? CNT_W : OFFS_W;
  localparam int DIV_CNT_W = $clog2(DIV_N);

  // configuration register indexes
  localparam logic CFG_ZERO = 1'b0;
  localparam logic CFG_MAX  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_ACCUM,
    S_MEAN,
    S_MEAN_WAIT,
    S_OFFS,
    S_MUL,
    S_ANG,
    S_ANG_WAIT,
    S_FINISH
  } state_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_N-1:0] dividend;
    logic [DIV_D-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_N-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/oan_divider.sv =====
// ----------------------------------------------------------------------------
// oan_divider
// Restoring radix-2 divider, one quotient bit per cycle. Shared by the mean
// and the angle computations; done pulses with the quotient in place.
// ----------------------------------------------------------------------------
`default_nettype none

module oan_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire oan_pkg::div_req_t req,
  output oan_pkg::div_rsp_t      rsp
);

  logic                           busy;
  logic                           done;
  logic [oan_pkg::DIV_CNT_W-1:0]  cnt;
  logic [oan_pkg::DIV_N-1:0]      quo;
  logic [oan_pkg::DIV_D-1:0]      rem;
  logic [oan_pkg::DIV_D-1:0]      dvs;

  logic [oan_pkg::DIV_D:0]        trial;
  logic [oan_pkg::DIV_D:0]        diff;

  // one trial subtraction
  always_comb begin
    trial = {rem, quo[oan_pkg::DIV_N-1]};
    diff  = trial - {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= oan_pkg::DIV_CNT_W'(oan_pkg::DIV_N - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[oan_pkg::DIV_D]) begin
        rem <= diff[oan_pkg::DIV_D-1:0];
        quo <= {quo[oan_pkg::DIV_N-2:0], 1'b1};
      end else begin
        rem <= trial[oan_pkg::DIV_D-1:0];
        quo <= {quo[oan_pkg::DIV_N-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== hdl/oversampled_angle_normalizer.sv =====
// ----------------------------------------------------------------------------
// oversampled_angle_normalizer
// Averages a burst of raw angle samples and scales it to 1/128 degree units.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries raw samples, one word per sample; s_tuser marks a good
//   reading, s_tlast the final sample of a burst. Mid-burst words are taken
//   at one per cycle and only accumulated.
//   m_* stream carries one result word per burst; m_tuser flags an empty
//   burst, in which case the last good results are repeated.
//   cfg_* writes zero_position (index 0) and max_position (index 1).
// Result sequence:
//   after the last sample of a burst with good readings the sequencer runs
//   the shared restoring divider twice, one quotient bit per cycle over a
//   29-bit dividend; an empty burst goes straight to the output register.
//   s_tready is low from the last sample until the result is loaded.
// Reset and stall:
//   rst clears accumulators, held results and the output valid flag, and sets
//   zero_position to 0 and max_position to 4095. A result waits in the
//   output register while m_tready is low; the next burst is accumulated
//   meanwhile and its result waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module oversampled_angle_normalizer (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_wen,
  input  wire logic        cfg_addr,
  input  wire logic [11:0] cfg_wdata,
  // sample stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // raw_sample[11:0], zero pad
  input  wire logic        s_tuser,   // sample_valid
  input  wire logic        s_tlast,   // last_sample
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // angle_q7, average_raw, offset_from_zero,
                                      // span, zero pad
  output logic             m_tuser    // no_samples
);

  oan_pkg::state_t                 state;
  oan_pkg::state_t                 state_next;

  logic [oan_pkg::RAW_W-1:0]       zero_pos;
  logic [oan_pkg::RAW_W-1:0]       max_pos;

  logic [oan_pkg::SUM_W-1:0]       sample_sum;
  logic [oan_pkg::CNT_W-1:0]       valid_count;
  logic [oan_pkg::SUM_W-1:0]       sample_sum_next;
  logic [oan_pkg::CNT_W-1:0]       valid_count_next;

  logic [oan_pkg::RAW_W-1:0]       held_average;
  logic [oan_pkg::OFFS_W-1:0]      held_offset;
  logic [oan_pkg::OFFS_W-1:0]      held_span;
  logic [oan_pkg::ANG_W-1:0]       held_angle;
  logic                            empty;

  logic [oan_pkg::PROD_W-1:0]      product;

  logic [oan_pkg::RAW_W-1:0]       offs_wrap;
  logic [oan_pkg::RAW_W-1:0]       span_wrap;
  logic [oan_pkg::OFFS_W-1:0]      span_full;
  logic [oan_pkg::OFFS_W-1:0]      offs_clamp;

  logic [oan_pkg::ANG_W-1:0]       out_angle;
  logic [oan_pkg::RAW_W-1:0]       out_avg;
  logic [oan_pkg::OFFS_W-1:0]      out_offs;
  logic [oan_pkg::OFFS_W-1:0]      out_span;
  logic                            out_empty;

  logic                            in_accept;
  logic                            out_free;
  logic                            out_load;

  oan_pkg::div_req_t               div_req;
  oan_pkg::div_rsp_t               div_rsp;

  // shared divider
  oan_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_pos <= '0;
      max_pos  <= '1;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        oan_pkg::CFG_ZERO: zero_pos <= cfg_wdata;
        oan_pkg::CFG_MAX:  max_pos  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // accumulator update for the incoming word
  always_comb begin
    sample_sum_next  = sample_sum;
    valid_count_next = valid_count;
    if (s_tuser && (valid_count < oan_pkg::CNT_W'(oan_pkg::MAX_BURST))) begin
      sample_sum_next  = sample_sum + oan_pkg::SUM_W'(s_tdata[oan_pkg::RAW_W-1:0]);
      valid_count_next = valid_count + 1'b1;
    end
  end

  // wrapped offset and span, offset clamped to span
  always_comb begin
    offs_wrap  = held_average - zero_pos;
    span_wrap  = max_pos - zero_pos;
    span_full  = (span_wrap == '0) ? oan_pkg::RAW_WRAP : {1'b0, span_wrap};
    offs_clamp = ({1'b0, offs_wrap} > span_full) ? span_full : {1'b0, offs_wrap};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      oan_pkg::S_ACCUM: begin
        if (in_accept && s_tlast) begin
          state_next = (valid_count_next == '0) ? oan_pkg::S_FINISH : oan_pkg::S_MEAN;
        end
      end
      oan_pkg::S_MEAN:      state_next = oan_pkg::S_MEAN_WAIT;
      oan_pkg::S_MEAN_WAIT: if (div_rsp.done) state_next = oan_pkg::S_OFFS;
      oan_pkg::S_OFFS:      state_next = oan_pkg::S_MUL;
      oan_pkg::S_MUL:       state_next = oan_pkg::S_ANG;
      oan_pkg::S_ANG:       state_next = oan_pkg::S_ANG_WAIT;
      oan_pkg::S_ANG_WAIT:  if (div_rsp.done) state_next = oan_pkg::S_FINISH;
      oan_pkg::S_FINISH:    if (out_free) state_next = oan_pkg::S_ACCUM;
      default:              state_next = oan_pkg::S_ACCUM;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready         = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = oan_pkg::DIV_N'(sample_sum);
    div_req.divisor  = oan_pkg::DIV_D'(valid_count);
    unique case (state)
      oan_pkg::S_ACCUM: s_tready = 1'b1;
      oan_pkg::S_MEAN:  div_req.start = 1'b1;
      oan_pkg::S_ANG: begin
        div_req.start    = 1'b1;
        div_req.dividend = oan_pkg::DIV_N'(product);
        div_req.divisor  = oan_pkg::DIV_D'(held_span);
      end
      oan_pkg::S_FINISH: out_load = out_free;
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oan_pkg::S_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // accumulators, held results and empty flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      valid_count  <= '0;
      held_average <= '0;
      held_offset  <= '0;
      held_span    <= '0;
      held_angle   <= '0;
      empty        <= 1'b0;
    end else begin
      if (in_accept) begin
        sample_sum  <= sample_sum_next;
        valid_count <= valid_count_next;
        empty       <= (valid_count_next == '0);
      end
      if (state == oan_pkg::S_MEAN_WAIT && div_rsp.done) begin
        held_average <= div_rsp.quotient[oan_pkg::RAW_W-1:0];
      end
      if (state == oan_pkg::S_OFFS) begin
        held_offset <= offs_clamp;
        held_span   <= span_full;
      end
      if (state == oan_pkg::S_ANG_WAIT && div_rsp.done) begin
        held_angle <= div_rsp.quotient[oan_pkg::ANG_W-1:0];
      end
      if (out_load) begin
        sample_sum  <= '0;
        valid_count <= '0;
      end
    end
  end

  // scaled offset, registered before the divider
  always_ff @(posedge clk) begin
    if (state == oan_pkg::S_MUL) begin
      product <= oan_pkg::PROD_W'(held_offset) * oan_pkg::PROD_W'(oan_pkg::FULL_Q7);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_angle <= held_angle;
      out_avg   <= held_average;
      out_offs  <= held_offset;
      out_span  <= held_span;
      out_empty <= empty;
    end
  end

  assign m_tdata = {2'b00, out_span, out_offs, out_avg, out_angle};
  assign m_tuser = out_empty;

  // divider is started only when idle
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // the angle divisor is never zero
  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == oan_pkg::S_ANG) |-> (held_span != '0))
    else $error("zero span at angle division");

  // valid count stays within the burst limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    valid_count <= oan_pkg::CNT_W'(oan_pkg::MAX_BURST))
    else $error("valid count above burst limit");

  // end of burst stops intake
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tlast) |=> !s_tready)
    else $error("input still ready after end of burst");

endmodule

`default_nettype wire

// ===== bench/tb_oversampled_angle_normalizer.sv =====
// ----------------------------------------------------------------------------
// tb_oversampled_angle_normalizer
// Self-checking bench for the burst-averaging angle normalizer. Bursts of raw
// samples stream in with random gaps, and results stream out with random
// backpressure and one long hold-off. A bit-accurate predictor of the mean,
// wrap, clamp and angle scaling checks every result word field by field.
// Settings sweep the span extremes (1 and 4096), the clamp, and an overlong
// burst.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_oversampled_angle_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 500;

  typedef struct {
    logic [oan_pkg::RAW_W-1:0] raw;
    logic                      good;
    logic                      last;
  } sample_word_t;

  typedef struct {
    logic [oan_pkg::ANG_W-1:0]  angle;
    logic [oan_pkg::RAW_W-1:0]  average;
    logic [oan_pkg::OFFS_W-1:0] offset;
    logic [oan_pkg::OFFS_W-1:0] span;
    logic                       empty;
  } angle_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic        cfg_addr = oan_pkg::CFG_ZERO;
  logic [11:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // raw_sample[11:0], zero pad
  logic        s_tuser = 1'b0; // sample_valid
  logic        s_tlast = 1'b0; // last_sample
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // angle_q7, average_raw, offset_from_zero, span, pad
  logic        m_tuser;        // no_samples

  oversampled_angle_normalizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_word_t  sample_queue[$];
  angle_result_t results_due[$];
  int unsigned   error_count  = 0;
  int unsigned   results_seen = 0;
  logic          idle_on  = 1'b1;
  logic          hold_off = 1'b0;
  int unsigned   send_gap  = 0;
  int unsigned   stall_left = 0;

  // predictor copy of registers and burst state
  logic [oan_pkg::RAW_W-1:0]  zero_pos = '0;
  logic [oan_pkg::RAW_W-1:0]  max_pos  = oan_pkg::RAW_W'(4095);
  int unsigned                burst_sum = 0;
  int unsigned                burst_cnt = 0;
  logic [oan_pkg::ANG_W-1:0]  held_angle  = '0;
  logic [oan_pkg::RAW_W-1:0]  held_avg    = '0;
  logic [oan_pkg::OFFS_W-1:0] held_offset = '0;
  logic [oan_pkg::OFFS_W-1:0] held_span   = '0;

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // fold one accepted sample into the burst, predict the result on the last one
  task automatic predict_angle(input logic [oan_pkg::RAW_W-1:0] raw, input logic good,
                               input logic last);
    angle_result_t              r;
    logic [oan_pkg::RAW_W-1:0]  mean;
    logic [oan_pkg::OFFS_W-1:0] offs;
    logic [oan_pkg::OFFS_W-1:0] sp;
    if (good && burst_cnt < oan_pkg::MAX_BURST) begin
      burst_sum += raw;
      burst_cnt++;
    end
    if (last) begin
      r.empty = (burst_cnt == 0);
      if (burst_cnt != 0) begin
        mean = oan_pkg::RAW_W'(burst_sum / burst_cnt);
        offs = oan_pkg::OFFS_W'(oan_pkg::RAW_W'(mean - zero_pos));
        sp   = oan_pkg::OFFS_W'(oan_pkg::RAW_W'(max_pos - zero_pos));
        if (sp == 0) sp = oan_pkg::RAW_WRAP;
        if (offs > sp) offs = sp;
        held_avg    = mean;
        held_offset = offs;
        held_span   = sp;
        held_angle  = oan_pkg::ANG_W'((longint'(offs) * longint'(oan_pkg::FULL_Q7))
                                      / longint'(sp));
      end
      burst_sum = 0;
      burst_cnt = 0;
      r.angle   = held_angle;
      r.average = held_avg;
      r.offset  = held_offset;
      r.span    = held_span;
      results_due.push_back(r);
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    sample_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        w = sample_queue.pop_front();
        s_tdata  <= {4'b0, w.raw};
        s_tuser  <= w.good;
        s_tlast  <= w.last;
        s_tvalid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) predict_angle(s_tdata[11:0], s_tuser, s_tlast);
  end

  // result backpressure
  always @(posedge clk) begin
    int unsigned g;
    if (rst || hold_off) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        stall_left <= g - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    angle_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (m_tdata[15:0] != want.angle)
          report_mismatch("angle_q7", m_tdata[15:0], want.angle);
        if (m_tdata[27:16] != want.average)
          report_mismatch("average_raw", m_tdata[27:16], want.average);
        if (m_tdata[40:28] != want.offset)
          report_mismatch("offset_from_zero", m_tdata[40:28], want.offset);
        if (m_tdata[53:41] != want.span)
          report_mismatch("span", m_tdata[53:41], want.span);
        if (m_tuser != want.empty)
          report_mismatch("no_samples", m_tuser, want.empty);
      end
    end
  end

  // long receiver hold-off once traffic is flowing, so the block backs up
  initial begin
    while (results_seen < 30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  initial begin
    #20ms;
    $display("oversampled_angle_normalizer regression: fail");
    $finish;
  end

  task automatic push_sample(input int raw, input logic good, input logic last);
    sample_word_t w;
    w.raw  = oan_pkg::RAW_W'(raw);
    w.good = good;
    w.last = last;
    sample_queue.push_back(w);
  endtask

  // random bursts: mostly short, some long, a few with every read failed
  task automatic queue_bursts(input int n_items);
    int sent;
    int len;
    int r;
    logic all_failed;
    logic good;
    int raw;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 6);
      else if (r < 90) len = $urandom_range(7, 20);
      else len = $urandom_range(21, 60);
      all_failed = ($urandom_range(0, 99) < 8);
      for (int i = 0; i < len; i++) begin
        good = !all_failed && ($urandom_range(0, 99) < 85);
        r = $urandom_range(0, 99);
        if (r < 5) raw = 0;
        else if (r < 10) raw = 4095;
        else raw = $urandom_range(0, 4095);
        push_sample(raw, good, i == len - 1);
      end
      sent += len;
    end
  endtask

  // wait until every word is sent and every result is back, then settle
  task automatic drain();
    while (sample_queue.size() != 0 || s_tvalid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input int value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= 12'(value);
    if (addr == oan_pkg::CFG_ZERO) zero_pos = oan_pkg::RAW_W'(value);
    else max_pos = oan_pkg::RAW_W'(value);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // stimulus
  initial begin
    int zero_set[6];
    int max_set[6];
    zero_set = '{4095, 1234, 0, 3000, 0, 2048};
    max_set  = '{0, 1234, 0, 1000, 4095, 1024};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty burst before any good one, extremes, failed reads
    push_sample(0, 1'b0, 1'b1);
    push_sample(0, 1'b1, 1'b1);
    push_sample(4095, 1'b1, 1'b1);
    push_sample(4095, 1'b1, 1'b0);
    push_sample(4094, 1'b1, 1'b1);
    push_sample(100, 1'b0, 1'b0);
    push_sample(200, 1'b1, 1'b1);
    push_sample(300, 1'b1, 1'b0);
    push_sample(4095, 1'b0, 1'b1);
    push_sample(0, 1'b0, 1'b0);
    push_sample(4095, 1'b0, 1'b1);
    push_sample(1, 1'b1, 1'b0);
    push_sample(2, 1'b1, 1'b0);
    push_sample(4094, 1'b0, 1'b0);
    push_sample(3, 1'b1, 1'b1);
    push_sample(0, 1'b0, 1'b1);
    drain();

    // clamp case: mean beyond the max position
    write_reg(oan_pkg::CFG_ZERO, 1000);
    write_reg(oan_pkg::CFG_MAX, 2000);
    push_sample(3000, 1'b1, 1'b1);
    push_sample(999, 1'b1, 1'b1);
    push_sample(2000, 1'b1, 1'b1);
    drain();

    // random traffic at the reset setting; the hold-off lands here
    write_reg(oan_pkg::CFG_ZERO, 0);
    write_reg(oan_pkg::CFG_MAX, 4095);
    queue_bursts(200);
    drain();

    // sweep of settings: span of 1, span of 4096, wrapped spans
    for (int p = 0; p < 6; p++) begin
      write_reg(oan_pkg::CFG_ZERO, zero_set[p]);
      write_reg(oan_pkg::CFG_MAX, max_set[p]);
      idle_on <= (p != 2);
      queue_bursts(110);
      drain();
    end

    // overlong burst past the accumulator limit, no idling
    write_reg(oan_pkg::CFG_ZERO, $urandom_range(0, 4095));
    write_reg(oan_pkg::CFG_MAX, $urandom_range(0, 4095));
    idle_on <= 1'b0;
    for (int i = 0; i < oan_pkg::MAX_BURST + 10; i++)
      push_sample($urandom_range(0, 4095), 1'b1, i == oan_pkg::MAX_BURST + 9);
    drain();
    idle_on <= 1'b1;

    if (results_due.size() != 0) begin
      $display("%0d results never arrived", results_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("oversampled_angle_normalizer regression: pass");
    end else begin
      $display("oversampled_angle_normalizer regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
